// ===== src/psb_pkg.sv =====
// Shared types, constants and tables for the particle step block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package psb_pkg;

	localparam int POS_W      = 24;
	localparam int ANG_W      = 16;
	localparam int TIME_W     = 16;
	localparam int SPEED_W    = 16;
	localparam int ARENA_W    = 12;
	localparam int START_W    = 20;
	localparam int HIT_W      = 2;
	localparam int CW         = 34;
	localparam int TRIG_W     = 17;
	localparam int ST_W       = SPEED_W + TIME_W;
	localparam int PROD_W     = ST_W + 1 + TRIG_W;
	localparam int ATAN_IDX_W = 5;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int RND_Q      = 15;

	localparam int CORDIC_STEPS_DEF = 16;
	localparam int FRAC_BITS_DEF    = 8;

	localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);
	localparam logic signed [CW-1:0] CR_UP       = CW'(1 << (RND_Q - 1));
	localparam logic signed [CW-1:0] CR_DN       = CW'((1 << (RND_Q - 1)) - 1);

	localparam logic [ANG_W-1:0] HALF_TURN = ANG_W'(32768);

	localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(8388607);
	localparam logic signed [POS_W-1:0] POS_MIN = POS_W'(-8388608);

	localparam logic [ARENA_W-1:0] ARENA_W_RST  = ARENA_W'(800);
	localparam logic [ARENA_W-1:0] ARENA_H_RST  = ARENA_W'(600);
	localparam logic [SPEED_W-1:0] SPEED_RST    = SPEED_W'(256);
	localparam logic [START_W-1:0] START_POS_RST = START_W'(25600);
	localparam logic [ANG_W-1:0]   START_ANG_RST = '0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ARENA_WIDTH   = 3'd0,
		REG_ARENA_HEIGHT  = 3'd1,
		REG_MOVE_SPEED    = 3'd2,
		REG_START_X       = 3'd3,
		REG_START_Y       = 3'd4,
		REG_START_HEADING = 3'd5
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALL,
		ST_CINIT,
		ST_CITER,
		ST_CRND,
		ST_MULX,
		ST_RNDX,
		ST_ADDX,
		ST_MULY,
		ST_RNDY,
		ST_ADDY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [TIME_W-1:0] elapsed_time;
		logic              restart;
	} step_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_x;
		logic signed [POS_W-1:0] new_y;
		logic [ANG_W-1:0]        new_heading;
		logic [HIT_W-1:0]        bounced;
	} result_t;

	typedef struct packed {
		logic [ARENA_W-1:0] arena_width;
		logic [ARENA_W-1:0] arena_height;
		logic [SPEED_W-1:0] move_speed;
		logic [START_W-1:0] start_x;
		logic [START_W-1:0] start_y;
		logic [ANG_W-1:0]   start_heading;
	} cfg_t;

	typedef struct packed {
		logic                  capture;
		logic                  load_start;
		logic                  wall;
		logic                  cinit;
		logic                  citer;
		logic                  crnd;
		logic                  mul;
		logic                  rnd;
		logic                  add;
		logic                  sel_y;
		logic                  out_load;
		logic [ATAN_IDX_W-1:0] iter;
	} cmd_t;

	function automatic logic signed [CW-1:0] atan_val(input logic [ATAN_IDX_W-1:0] i);
		case (i)
			5'd0:    atan_val = CW'(536870912);
			5'd1:    atan_val = CW'(316933406);
			5'd2:    atan_val = CW'(167458907);
			5'd3:    atan_val = CW'(85004756);
			5'd4:    atan_val = CW'(42667331);
			5'd5:    atan_val = CW'(21354465);
			5'd6:    atan_val = CW'(10680862);
			5'd7:    atan_val = CW'(5341269);
			5'd8:    atan_val = CW'(2670163);
			5'd9:    atan_val = CW'(1335087);
			5'd10:   atan_val = CW'(667544);
			5'd11:   atan_val = CW'(333772);
			5'd12:   atan_val = CW'(166886);
			5'd13:   atan_val = CW'(83443);
			5'd14:   atan_val = CW'(41722);
			5'd15:   atan_val = CW'(20861);
			5'd16:   atan_val = CW'(10430);
			5'd17:   atan_val = CW'(5215);
			5'd18:   atan_val = CW'(2608);
			5'd19:   atan_val = CW'(1304);
			5'd20:   atan_val = CW'(652);
			5'd21:   atan_val = CW'(326);
			5'd22:   atan_val = CW'(163);
			5'd23:   atan_val = CW'(81);
			default: atan_val = '0;
		endcase
	endfunction

endpackage

`default_nettype wire

// ===== src/particle_step_with_wall_bounce.sv =====
// Particle step with wall reflection: one result per request.
// A motion request runs the wall check, the serial CORDIC loop and the motion steps;
// a restart request only loads the start state. One request is in work at a time,
// and the output register holds a result while the next runs.
// Reset clears control, loads position 100.0, 100.0 and heading 0, and the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module particle_step_with_wall_bounce import psb_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  step_valid,
	output logic                       step_stall,
	input  wire step_t                 step,
	output logic                       result_valid,
	input  wire logic                  result_stall,
	output result_t                    result,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.arena_width   <= ARENA_W_RST;
			cfg_q.arena_height  <= ARENA_H_RST;
			cfg_q.move_speed    <= SPEED_RST;
			cfg_q.start_x       <= START_POS_RST;
			cfg_q.start_y       <= START_POS_RST;
			cfg_q.start_heading <= START_ANG_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ARENA_WIDTH:   cfg_q.arena_width   <= cfg_data[ARENA_W-1:0];
				REG_ARENA_HEIGHT:  cfg_q.arena_height  <= cfg_data[ARENA_W-1:0];
				REG_MOVE_SPEED:    cfg_q.move_speed    <= cfg_data[SPEED_W-1:0];
				REG_START_X:       cfg_q.start_x       <= cfg_data[START_W-1:0];
				REG_START_Y:       cfg_q.start_y       <= cfg_data[START_W-1:0];
				REG_START_HEADING: cfg_q.start_heading <= cfg_data[ANG_W-1:0];
				default: ;
			endcase
		end
	end

	psb_ctrl #(
		.CORDIC_STEPS(CORDIC_STEPS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step_valid   (step_valid),
		.step_restart (step.restart),
		.step_stall   (step_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	psb_dpath #(
		.FRAC_BITS(FRAC_BITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.cfg          (cfg_q),
		.elapsed_time (step.elapsed_time),
		.result       (result)
	);

endmodule

`default_nettype wire

// ===== src/psb_ctrl.sv =====
// Sequencer for the particle step: walls, CORDIC iterations, motion, result.
// Depends on psb_pkg; drives the command struct into psb_dpath.
`timescale 1ns / 1ps
`default_nettype none

module psb_ctrl import psb_pkg::*; #(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step_valid,
	input  wire logic step_restart,
	output logic      step_stall,
	output logic      result_valid,
	input  wire logic result_stall,
	output cmd_t      cmd
);

	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic [IW-1:0] ITER_LAST = IW'(CORDIC_STEPS - 1);

	state_t        state_q, state_d;
	logic [IW-1:0] iter_q, iter_d;
	logic          out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			iter_q      <= iter_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		iter_d   = iter_q;
		cmd      = '0;
		cmd.iter = ATAN_IDX_W'(iter_q);
		case (state_q)
			ST_IDLE: begin
				if (step_valid) begin
					if (step_restart) begin
						cmd.load_start = 1'b1;
						state_d        = ST_DONE;
					end else begin
						cmd.capture = 1'b1;
						state_d     = ST_WALL;
					end
				end
			end
			ST_WALL: begin
				cmd.wall = 1'b1;
				state_d  = ST_CINIT;
			end
			ST_CINIT: begin
				cmd.cinit = 1'b1;
				iter_d    = '0;
				state_d   = ST_CITER;
			end
			ST_CITER: begin
				cmd.citer = 1'b1;
				iter_d    = iter_q + 1'b1;
				if (iter_q == ITER_LAST) begin
					state_d = ST_CRND;
				end
			end
			ST_CRND: begin
				cmd.crnd = 1'b1;
				state_d  = ST_MULX;
			end
			ST_MULX: begin
				cmd.mul = 1'b1;
				state_d = ST_RNDX;
			end
			ST_RNDX: begin
				cmd.rnd = 1'b1;
				state_d = ST_ADDX;
			end
			ST_ADDX: begin
				cmd.add = 1'b1;
				state_d = ST_MULY;
			end
			ST_MULY: begin
				cmd.mul   = 1'b1;
				cmd.sel_y = 1'b1;
				state_d   = ST_RNDY;
			end
			ST_RNDY: begin
				cmd.rnd   = 1'b1;
				cmd.sel_y = 1'b1;
				state_d   = ST_ADDY;
			end
			ST_ADDY: begin
				cmd.add   = 1'b1;
				cmd.sel_y = 1'b1;
				state_d   = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !result_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		if (cmd.out_load) begin
			out_valid_d = 1'b1;
		end else if (result_stall) begin
			out_valid_d = out_valid_q;
		end else begin
			out_valid_d = 1'b0;
		end
	end

	assign step_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;

	a_iter_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CITER) |-> (iter_q <= ITER_LAST))
		else $error("CORDIC iteration count out of range");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(step_valid && !step_stall) |=> (state_q != ST_IDLE))
		else $error("request accepted without leaving idle");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_valid_q && result_stall) |=> (state_q == ST_DONE))
		else $error("result overwritten while output stalled");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside completion");

endmodule

`default_nettype wire

// ===== src/psb_dpath.sv =====
// Datapath for the particle step: state, wall logic, serial CORDIC, motion.
// Depends on psb_pkg; sequenced by the command struct from psb_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module psb_dpath import psb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire cfg_t cfg,
	input  wire logic [TIME_W-1:0] elapsed_time,
	output result_t   result
);

	localparam int SHIFT = 35 - FRAC_BITS;
	localparam int RW    = PROD_W - SHIFT;
	localparam int SW    = ((RW > POS_W) ? RW : POS_W) + 1;
	localparam int TW    = ARENA_W + 2 + FRAC_BITS;
	localparam int SATW  = (TW > SW) ? TW : SW;

	localparam logic signed [POS_W-1:0]  LO_LIM  = POS_W'(2 * (1 << FRAC_BITS));
	localparam logic signed [POS_W-1:0]  LO_SET  = POS_W'(3 * (1 << FRAC_BITS));
	localparam logic signed [PROD_W-1:0] P_UP    = PROD_W'(64'd1 << (SHIFT - 1));
	localparam logic signed [PROD_W-1:0] P_DN    = PROD_W'((64'd1 << (SHIFT - 1)) - 64'd1);
	localparam logic signed [SATW-1:0]   SAT_HI  = SATW'(POS_MAX);
	localparam logic signed [SATW-1:0]   SAT_LO  = SATW'(POS_MIN);

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SATW-1:0] v);
		if (v > SAT_HI) begin
			sat_pos = POS_MAX;
		end else if (v < SAT_LO) begin
			sat_pos = POS_MIN;
		end else begin
			sat_pos = v[POS_W-1:0];
		end
	endfunction

	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [ANG_W-1:0]         heading_q;
	logic [HIT_W-1:0]         hit_q;
	logic [TIME_W-1:0]        dt_q;
	logic [ST_W-1:0]          st_q;
	logic signed [CW-1:0]     cx_q, cy_q, cz_q;
	logic                     neg_q;
	logic signed [TRIG_W-1:0] c_q, s_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [RW-1:0]     rnd_q;
	result_t                  res_q;

	logic signed [ARENA_W+1:0] wx_m2, wx_m3, wy_m2, wy_m3;
	logic signed [POS_W-1:0]   hi_x, set_x, hi_y, set_y;
	logic signed [POS_W-1:0]   wall_x, wall_y;
	logic                      hit_x, hit_y;
	logic [ANG_W-1:0]          head_1, head_2;

	logic signed [TRIG_W:0]    ang_s, ang_f;
	logic                      fold_neg;
	logic signed [CW-1:0]      sx, sy, at;
	logic signed [CW-1:0]      xr, yr;
	logic signed [TRIG_W-1:0]  c_r, s_r;
	logic signed [TRIG_W-1:0]  mop;
	logic signed [PROD_W-1:0]  rnd_full;
	logic signed [POS_W-1:0]   pos_sel;
	logic signed [POS_W-1:0]   pos_new;

	// wall limits
	always_comb begin
		wx_m2 = $signed({2'b00, cfg.arena_width}) - 14'sd2;
		wx_m3 = $signed({2'b00, cfg.arena_width}) - 14'sd3;
		wy_m2 = $signed({2'b00, cfg.arena_height}) - 14'sd2;
		wy_m3 = $signed({2'b00, cfg.arena_height}) - 14'sd3;
		hi_x  = sat_pos(SATW'(wx_m2) <<< FRAC_BITS);
		set_x = sat_pos(SATW'(wx_m3) <<< FRAC_BITS);
		hi_y  = sat_pos(SATW'(wy_m2) <<< FRAC_BITS);
		set_y = sat_pos(SATW'(wy_m3) <<< FRAC_BITS);

		hit_x  = 1'b1;
		wall_x = pos_x_q;
		if (pos_x_q < LO_LIM) begin
			wall_x = LO_SET;
		end else if (pos_x_q > hi_x) begin
			wall_x = set_x;
		end else begin
			hit_x = 1'b0;
		end
		hit_y  = 1'b1;
		wall_y = pos_y_q;
		if (pos_y_q < LO_LIM) begin
			wall_y = LO_SET;
		end else if (pos_y_q > hi_y) begin
			wall_y = set_y;
		end else begin
			hit_y = 1'b0;
		end
		head_1 = hit_x ? ANG_W'(HALF_TURN - heading_q) : heading_q;
		head_2 = hit_y ? ANG_W'(-head_1) : head_1;
	end

	// fold heading into the right half plane
	always_comb begin
		ang_s    = $signed({{2{heading_q[ANG_W-1]}}, heading_q});
		ang_f    = ang_s;
		fold_neg = 1'b0;
		if (ang_s > 17'sd16384) begin
			ang_f    = ang_s - 17'sd32768;
			fold_neg = 1'b1;
		end else if (ang_s < -17'sd16384) begin
			ang_f    = ang_s + 17'sd32768;
			fold_neg = 1'b1;
		end
	end

	always_comb begin
		sx       = cx_q >>> cmd.iter;
		sy       = cy_q >>> cmd.iter;
		at       = atan_val(cmd.iter);
		xr       = (cx_q + (cx_q[CW-1] ? CR_DN : CR_UP)) >>> RND_Q;
		yr       = (cy_q + (cy_q[CW-1] ? CR_DN : CR_UP)) >>> RND_Q;
		c_r      = xr[TRIG_W-1:0];
		s_r      = yr[TRIG_W-1:0];
		mop      = cmd.sel_y ? s_q : c_q;
		rnd_full = (prod_q + (prod_q[PROD_W-1] ? P_DN : P_UP)) >>> SHIFT;
		pos_sel  = cmd.sel_y ? pos_y_q : pos_x_q;
		pos_new  = sat_pos(SATW'(SW'(pos_sel) + SW'(rnd_q)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q   <= POS_W'(START_POS_RST);
			pos_y_q   <= POS_W'(START_POS_RST);
			heading_q <= '0;
		end else if (cmd.load_start) begin
			pos_x_q   <= POS_W'(cfg.start_x);
			pos_y_q   <= POS_W'(cfg.start_y);
			heading_q <= cfg.start_heading;
		end else if (cmd.wall) begin
			pos_x_q   <= wall_x;
			pos_y_q   <= wall_y;
			heading_q <= head_2;
		end else if (cmd.add) begin
			if (cmd.sel_y) begin
				pos_y_q <= pos_new;
			end else begin
				pos_x_q <= pos_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			hit_q <= '0;
		end
		if (cmd.capture) begin
			dt_q <= elapsed_time;
		end
		if (cmd.wall) begin
			hit_q <= {hit_y, hit_x};
			st_q  <= ST_W'(cfg.move_speed) * ST_W'(dt_q);
		end
		if (cmd.cinit) begin
			cx_q  <= CORDIC_GAIN;
			cy_q  <= '0;
			cz_q  <= CW'(ang_f) <<< 16;
			neg_q <= fold_neg;
		end
		if (cmd.citer) begin
			if (!cz_q[CW-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				cz_q <= cz_q + at;
			end
		end
		if (cmd.crnd) begin
			c_q <= neg_q ? -c_r : c_r;
			s_q <= neg_q ? -s_r : s_r;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'($signed({1'b0, st_q})) * PROD_W'(mop);
		end
		if (cmd.rnd) begin
			rnd_q <= rnd_full[RW-1:0];
		end
		if (cmd.out_load) begin
			res_q.new_x       <= pos_x_q;
			res_q.new_y       <= pos_y_q;
			res_q.new_heading <= heading_q;
			res_q.bounced     <= hit_q;
		end
	end

	assign result = res_q;

endmodule

`default_nettype wire
